// ===== sv/lpwa_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lpwa_pkg: shared types and constants of the load window averager
// Payload structs, divider and window control structs, register indexes.
// ---------------------------------------------------------------------------
package lpwa_pkg;

    // load scale: percent times 256
    localparam int FULL_LOAD = 25600;
    localparam int LOAD_W    = 15;

    // default window depths
    localparam int SHORT_DEPTH_DEF = 4;
    localparam int MID_DEPTH_DEF   = 20;
    localparam int LONG_DEPTH_DEF  = 60;

    // shared divider: 47-bit dividend, 33-bit divisor, 15-bit quotient
    localparam int NUM_W = 47;
    localparam int DIV_W = 33;
    localparam int QUO_W = LOAD_W;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASELINE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LOOP    = 2'd2;

    // config reset values
    localparam logic [15:0] BASELINE_RST = 16'd240;
    localparam logic [15:0] MAX_LOOP_RST = 16'd5600;

    // source modes
    localparam logic MODE_TICKS = 1'b0;
    localparam logic MODE_LOOP  = 1'b1;

    typedef struct packed {
        logic [31:0] busy_cnt;
        logic [31:0] free_cnt;
        logic [15:0] loop_period;
    } in_t;

    typedef struct packed {
        logic [LOAD_W-1:0] avg_short;
        logic [LOAD_W-1:0] avg_mid;
        logic [LOAD_W-1:0] avg_long;
    } out_t;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quotient;
    } div_rsp_t;

    typedef struct packed {
        logic rd;
        logic wr;
    } win_ctrl_t;

    // address bits for a store of the given depth
    function automatic int addr_width(int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

    // running sum bits for a window of the given depth
    function automatic int sum_width(int depth);
        return $clog2(depth * FULL_LOAD + 1);
    endfunction

endpackage

// ===== sv/lpwa_ram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lpwa_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module lpwa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                     aclk,
    input  logic                                     we,
    input  logic [lpwa_pkg::addr_width(DEPTH)-1:0]   waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [lpwa_pkg::addr_width(DEPTH)-1:0]   raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== sv/lpwa_div.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lpwa_div: shared restoring divider
// One quotient bit per cycle; the quotient must fit in QUO_W bits.
// ---------------------------------------------------------------------------
module lpwa_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  lpwa_pkg::div_req_t  req,
    output lpwa_pkg::div_rsp_t  rsp
);

    localparam int CNT_W = $clog2(lpwa_pkg::QUO_W);

    logic [lpwa_pkg::DIV_W-1:0] rem_reg, rem_next;
    logic [lpwa_pkg::DIV_W-1:0] dvs_reg;
    logic [lpwa_pkg::QUO_W-1:0] shq_reg, shq_next;
    logic [CNT_W-1:0]           cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;
    logic [lpwa_pkg::DIV_W:0]   trial;
    logic [lpwa_pkg::DIV_W:0]   diff;
    logic                       ge;

    // one restoring step: shift in next dividend bit, try subtract
    always_comb begin
        trial    = {rem_reg, shq_reg[lpwa_pkg::QUO_W-1]};
        diff     = trial - {1'b0, dvs_reg};
        ge       = ~diff[lpwa_pkg::DIV_W];
        rem_next = ge ? diff[lpwa_pkg::DIV_W-1:0] : trial[lpwa_pkg::DIV_W-1:0];
        shq_next = {shq_reg[lpwa_pkg::QUO_W-2:0], ge};
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(lpwa_pkg::QUO_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath; high dividend part starts as the partial remainder
    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg <= lpwa_pkg::DIV_W'(req.dividend[lpwa_pkg::NUM_W-1:lpwa_pkg::QUO_W]);
            shq_reg <= req.dividend[lpwa_pkg::QUO_W-1:0];
            dvs_reg <= req.divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            shq_reg <= shq_next;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = shq_reg;

endmodule

// ===== sv/lpwa_window.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lpwa_window: one ring window with running sum
// Ring in RAM; entries not yet written since reset read as zero.
// ---------------------------------------------------------------------------
module lpwa_window #(
    parameter int DEPTH = 4
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  lpwa_pkg::win_ctrl_t                    ctrl,
    input  logic [lpwa_pkg::LOAD_W-1:0]            load,
    output logic [lpwa_pkg::sum_width(DEPTH)-1:0]  sum
);

    localparam int AW = lpwa_pkg::addr_width(DEPTH);
    localparam int SW = lpwa_pkg::sum_width(DEPTH);

    logic [AW-1:0]               pos_reg;
    logic                        wrapped_reg;
    logic [SW-1:0]               sum_reg, sum_next;
    logic [lpwa_pkg::LOAD_W-1:0] rdata;
    logic [lpwa_pkg::LOAD_W-1:0] old_val;
    logic                        last_pos;

    lpwa_ram #(
        .WIDTH (lpwa_pkg::LOAD_W),
        .DEPTH (DEPTH)
    ) u_ring (
        .aclk  (aclk),
        .we    (ctrl.wr),
        .waddr (pos_reg),
        .wdata (load),
        .re    (ctrl.rd),
        .raddr (pos_reg),
        .rdata (rdata)
    );

    // oldest entry drops out of the sum; unwritten entries count as zero
    always_comb begin
        old_val  = wrapped_reg ? rdata : '0;
        sum_next = sum_reg - SW'(old_val) + SW'(load);
        last_pos = (pos_reg == AW'(DEPTH - 1));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            wrapped_reg <= 1'b0;
            sum_reg     <= '0;
        end else if (ctrl.wr) begin
            sum_reg <= sum_next;
            if (last_pos) begin
                pos_reg     <= '0;
                wrapped_reg <= 1'b1;
            end else begin
                pos_reg <= pos_reg + 1'b1;
            end
        end
    end

    assign sum = sum_reg;

endmodule

// ===== sv/load_percent_window_averager_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// load_percent_window_averager_unit: load percent with three window averages
// Each request steps through the load division (skipped when the load saturates or
// the loop time span is empty), the window update and the three average divisions,
// then waits until the result register is free; a silent sample gives no result.
// One request at a time: s_ready is high only in idle, so a new request is taken once the last one is done.
// Reset (synchronous, active low) clears state; windows read as zero until
// written, so no clearing pass is needed.
// ---------------------------------------------------------------------------
module load_percent_window_averager_unit #(
    parameter int SHORT_DEPTH = lpwa_pkg::SHORT_DEPTH_DEF,
    parameter int MID_DEPTH   = lpwa_pkg::MID_DEPTH_DEF,
    parameter int LONG_DEPTH  = lpwa_pkg::LONG_DEPTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  lpwa_pkg::in_t                     s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output lpwa_pkg::out_t                    m_data,
    input  logic                              cfg_we,
    input  logic [lpwa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lpwa_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    localparam int SSW = lpwa_pkg::sum_width(SHORT_DEPTH);
    localparam int MSW = lpwa_pkg::sum_width(MID_DEPTH);
    localparam int LSW = lpwa_pkg::sum_width(LONG_DEPTH);

    typedef enum logic [12:0] {
        ST_IDLE   = 13'b0000000000001,
        ST_CALC   = 13'b0000000000010,
        ST_MUL    = 13'b0000000000100,
        ST_WAIT_L = 13'b0000000001000,
        ST_RD     = 13'b0000000010000,
        ST_UPD    = 13'b0000000100000,
        ST_AVG_S  = 13'b0000001000000,
        ST_WAIT_S = 13'b0000010000000,
        ST_AVG_M  = 13'b0000100000000,
        ST_WAIT_M = 13'b0001000000000,
        ST_AVG_G  = 13'b0010000000000,
        ST_WAIT_G = 13'b0100000000000,
        ST_FIN    = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic        mode_reg;
    logic [15:0] base_reg;
    logic [15:0] max_reg;

    // sample state
    logic        primed_reg;
    logic [31:0] prev_act_reg;
    logic [31:0] prev_idl_reg;
    lpwa_pkg::in_t in_reg;

    // working registers
    logic [31:0]                    opnd_reg;
    logic [lpwa_pkg::DIV_W-1:0]     den_reg;
    logic [lpwa_pkg::LOAD_W-1:0]    load_reg;
    logic [lpwa_pkg::LOAD_W-1:0]    avg_s_reg;
    logic [lpwa_pkg::LOAD_W-1:0]    avg_m_reg;
    logic [lpwa_pkg::LOAD_W-1:0]    avg_g_reg;
    logic                           m_valid_reg;
    lpwa_pkg::out_t                 m_data_reg;

    // sample math
    logic [31:0] da, di;
    logic [32:0] total;
    logic [15:0] lt, lx, ld;

    lpwa_pkg::div_req_t  div_req;
    lpwa_pkg::div_rsp_t  div_rsp;
    lpwa_pkg::win_ctrl_t win_ctrl;
    logic [SSW-1:0] sum_s;
    logic [MSW-1:0] sum_m;
    logic [LSW-1:0] sum_g;
    logic           out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign out_free = ~m_valid_reg | m_ready;

    always_comb begin
        da    = in_reg.busy_cnt - prev_act_reg;
        di    = in_reg.free_cnt - prev_idl_reg;
        total = {1'b0, da} + {1'b0, di};
        lt    = (in_reg.loop_period < base_reg) ? base_reg : in_reg.loop_period;
        lx    = lt - base_reg;
        ld    = max_reg - base_reg;
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= lpwa_pkg::MODE_TICKS;
            base_reg <= lpwa_pkg::BASELINE_RST;
            max_reg  <= lpwa_pkg::MAX_LOOP_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                lpwa_pkg::CFG_SOURCE_MODE: begin
                    mode_reg <= cfg_wdata[0];
                end
                lpwa_pkg::CFG_BASELINE: begin
                    base_reg <= cfg_wdata;
                end
                lpwa_pkg::CFG_MAX_LOOP: begin
                    max_reg <= cfg_wdata;
                end
                default: begin
                end
            endcase
        end
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_CALC;
            end
            ST_CALC: begin
                if (!primed_reg) begin
                    state_next = ST_IDLE;
                end else if (mode_reg == lpwa_pkg::MODE_TICKS) begin
                    state_next = (total == '0) ? ST_IDLE : ST_MUL;
                end else if (max_reg <= base_reg || lx >= ld) begin
                    state_next = ST_RD;
                end else begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:    state_next = ST_WAIT_L;
            ST_WAIT_L: begin
                if (div_rsp.done) state_next = ST_RD;
            end
            ST_RD:     state_next = ST_UPD;
            ST_UPD:    state_next = ST_AVG_S;
            ST_AVG_S:  state_next = ST_WAIT_S;
            ST_WAIT_S: begin
                if (div_rsp.done) state_next = ST_AVG_M;
            end
            ST_AVG_M:  state_next = ST_WAIT_M;
            ST_WAIT_M: begin
                if (div_rsp.done) state_next = ST_AVG_G;
            end
            ST_AVG_G:  state_next = ST_WAIT_G;
            ST_WAIT_G: begin
                if (div_rsp.done) state_next = ST_FIN;
            end
            ST_FIN: begin
                if (out_free) state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // divider request and window strobes
    always_comb begin
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        win_ctrl.rd      = (state_reg == ST_RD);
        win_ctrl.wr      = (state_reg == ST_UPD);
        case (state_reg)
            ST_MUL: begin
                div_req.start    = 1'b1;
                div_req.dividend = lpwa_pkg::NUM_W'(opnd_reg) *
                                   lpwa_pkg::NUM_W'(lpwa_pkg::FULL_LOAD);
                div_req.divisor  = den_reg;
            end
            ST_AVG_S: begin
                div_req.start    = 1'b1;
                div_req.dividend = lpwa_pkg::NUM_W'(sum_s);
                div_req.divisor  = lpwa_pkg::DIV_W'(SHORT_DEPTH);
            end
            ST_AVG_M: begin
                div_req.start    = 1'b1;
                div_req.dividend = lpwa_pkg::NUM_W'(sum_m);
                div_req.divisor  = lpwa_pkg::DIV_W'(MID_DEPTH);
            end
            ST_AVG_G: begin
                div_req.start    = 1'b1;
                div_req.dividend = lpwa_pkg::NUM_W'(sum_g);
                div_req.divisor  = lpwa_pkg::DIV_W'(LONG_DEPTH);
            end
            default: begin
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            primed_reg   <= 1'b0;
            prev_act_reg <= '0;
            prev_idl_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CALC) begin
                primed_reg <= 1'b1;
                if (mode_reg == lpwa_pkg::MODE_TICKS) begin
                    prev_act_reg <= in_reg.busy_cnt;
                    prev_idl_reg <= in_reg.free_cnt;
                end
            end
            if (state_reg == ST_FIN && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        // load operands; saturated loads and an empty loop time span skip the divider
        if (state_reg == ST_CALC) begin
            if (mode_reg == lpwa_pkg::MODE_TICKS) begin
                opnd_reg <= da;
                den_reg  <= total;
            end else begin
                opnd_reg <= 32'(lx);
                den_reg  <= lpwa_pkg::DIV_W'(ld);
                if (max_reg <= base_reg) begin
                    load_reg <= '0;
                end else begin
                    load_reg <= lpwa_pkg::LOAD_W'(lpwa_pkg::FULL_LOAD);
                end
            end
        end
        if (div_rsp.done) begin
            case (state_reg)
                ST_WAIT_L: load_reg  <= div_rsp.quotient;
                ST_WAIT_S: avg_s_reg <= div_rsp.quotient;
                ST_WAIT_M: avg_m_reg <= div_rsp.quotient;
                ST_WAIT_G: avg_g_reg <= div_rsp.quotient;
                default: begin
                end
            endcase
        end
        if (state_reg == ST_FIN && out_free) begin
            m_data_reg.avg_short <= avg_s_reg;
            m_data_reg.avg_mid   <= avg_m_reg;
            m_data_reg.avg_long  <= avg_g_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    lpwa_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    lpwa_window #(.DEPTH(SHORT_DEPTH)) u_win_short (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (win_ctrl),
        .load    (load_reg),
        .sum     (sum_s)
    );

    lpwa_window #(.DEPTH(MID_DEPTH)) u_win_mid (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (win_ctrl),
        .load    (load_reg),
        .sum     (sum_m)
    );

    lpwa_window #(.DEPTH(LONG_DEPTH)) u_win_long (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (win_ctrl),
        .load    (load_reg),
        .sum     (sum_g)
    );

endmodule

// ===== tb/sv/load_percent_window_averager_unit_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// load_percent_window_averager_unit_test: self-checking bench for the load averager
// Drives tick-counter and loop-time samples through the request channel and
// tracks the instantaneous load and the short, middle and long window sums in
// a cycle-free mirror. Every result is checked against the oldest pending
// average. Directed cases cover priming, zero tick totals, counter wrap, loop
// time saturation and degenerate loop time spans. Random phases then vary the
// source mode and loop time limits, with bursts of idling on both channels.
// ---------------------------------------------------------------------------
module load_percent_window_averager_unit_test;

    // spare register index: writes there must be ignored
    localparam logic [lpwa_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int STALL_LIMIT  = 2000;
    localparam int SETTLE_CYCLES = 100;
    localparam int RAND_PHASES   = 12;
    localparam int PHASE_SAMPLES = 160;

    logic                            aclk;
    logic                            aresetn;
    logic                            s_valid;
    logic                            s_ready;
    lpwa_pkg::in_t                   s_data;
    logic                            m_valid;
    logic                            m_ready;
    lpwa_pkg::out_t                  m_data;
    logic                            cfg_we;
    logic [lpwa_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [lpwa_pkg::CFG_DATA_W-1:0] cfg_wdata;

    // mirror of the block's registers and state
    logic        cur_mode;
    logic [15:0] cur_base;
    logic [15:0] cur_max;
    logic        primed;
    logic [31:0] last_active;
    logic [31:0] last_idle;
    logic [lpwa_pkg::LOAD_W-1:0] win_ring [3][lpwa_pkg::LONG_DEPTH_DEF];
    int          win_depth [3];
    int          win_pos [3];
    int unsigned win_sum [3];
    lpwa_pkg::out_t pending_avgs [$];

    // run control and bookkeeping
    bit          idle_on;
    int          errors;
    int          samples_sent;
    int          avgs_checked;
    int          reg_writes;
    int          stall_cycles;
    logic [31:0] act_cnt;
    logic [31:0] idl_cnt;

    load_percent_window_averager_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Update the mirror with one accepted sample and queue the averages it yields.
    function automatic void account_sample(lpwa_pkg::in_t smp);
        logic [31:0]     da;
        logic [31:0]     di;
        logic [32:0]     total;
        logic [15:0]     lt;
        longint unsigned num;
        longint unsigned quo;
        int unsigned     load;
        int              p;
        bit              first;
        lpwa_pkg::out_t  avgs;
        first  = !primed;
        primed = 1'b1;
        if (cur_mode == lpwa_pkg::MODE_TICKS) begin
            da    = smp.busy_cnt - last_active;
            di    = smp.free_cnt - last_idle;
            total = {1'b0, da} + {1'b0, di};
            last_active = smp.busy_cnt;
            last_idle   = smp.free_cnt;
            if (first || total == '0)
                return;
            num  = 64'(da);
            quo  = (num * lpwa_pkg::FULL_LOAD) / longint'(total);
            load = 32'(quo);
        end else begin
            if (first)
                return;
            lt = (smp.loop_period < cur_base) ? cur_base : smp.loop_period;
            if (cur_max <= cur_base) begin
                load = 0;
            end else begin
                num  = 64'(lt - cur_base);
                quo  = (num * lpwa_pkg::FULL_LOAD) / longint'(cur_max - cur_base);
                load = (quo > 64'(lpwa_pkg::FULL_LOAD)) ? 32'(lpwa_pkg::FULL_LOAD) :
                       32'(quo);
            end
        end
        // running sums over the three rings
        for (int w = 0; w < 3; w++) begin
            p = win_pos[w];
            win_sum[w]    = win_sum[w] - win_ring[w][p] + load;
            win_ring[w][p] = lpwa_pkg::LOAD_W'(load);
            win_pos[w]    = (p + 1 >= win_depth[w]) ? 0 : p + 1;
        end
        avgs.avg_short = lpwa_pkg::LOAD_W'(win_sum[0] / win_depth[0]);
        avgs.avg_mid   = lpwa_pkg::LOAD_W'(win_sum[1] / win_depth[1]);
        avgs.avg_long  = lpwa_pkg::LOAD_W'(win_sum[2] / win_depth[2]);
        pending_avgs.push_back(avgs);
    endfunction

    // One request. Valid stays high on return: the caller sends again or
    // calls wait_idle in the same time step.
    task automatic send_sample(input logic [31:0] act, input logic [31:0] idl,
                               input logic [15:0] lt);
        lpwa_pkg::in_t smp;
        smp.busy_cnt    = act;
        smp.free_cnt    = idl;
        smp.loop_period = lt;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= smp;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        account_sample(smp);
        samples_sent++;
    endtask

    // Drop valid, let all results drain and give a silent sample time to finish.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_avgs.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [lpwa_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            lpwa_pkg::CFG_SOURCE_MODE: cur_mode = val[0];
            lpwa_pkg::CFG_BASELINE:    cur_base = val;
            lpwa_pkg::CFG_MAX_LOOP:    cur_max  = val;
            default: ;
        endcase
        reg_writes++;
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    // Loop time mode first, so the priming sample is taken in that mode.
    task automatic test_loop_time_mode();
        idle_on = 1'b1;
        write_reg(lpwa_pkg::CFG_SOURCE_MODE, 16'(lpwa_pkg::MODE_LOOP));
        send_sample($urandom, $urandom, 16'd3000);   // primes, no result
        send_sample($urandom, $urandom, 16'd0);      // below baseline
        send_sample($urandom, $urandom, 16'd240);
        send_sample($urandom, $urandom, 16'd5600);   // full load
        send_sample($urandom, $urandom, 16'hFFFF);   // saturates
        send_sample($urandom, $urandom, 16'd2920);   // half load
        wait_idle();
        write_reg(CFG_SPARE, 16'hFFFF);
        write_reg(lpwa_pkg::CFG_BASELINE, 16'd1000);
        write_reg(lpwa_pkg::CFG_MAX_LOOP, 16'd1000); // max equal to baseline
        send_sample($urandom, $urandom, 16'hFFFF);
        wait_idle();
        write_reg(lpwa_pkg::CFG_MAX_LOOP, 16'd500);  // max below baseline
        send_sample($urandom, $urandom, 16'd2000);
        wait_idle();
        write_reg(lpwa_pkg::CFG_BASELINE, 16'd0);
        write_reg(lpwa_pkg::CFG_MAX_LOOP, 16'hFFFF);
        send_sample($urandom, $urandom, 16'hFFFF);
        send_sample($urandom, $urandom, 16'd1);
        send_sample($urandom, $urandom, 16'd32768);
        wait_idle();
        write_reg(lpwa_pkg::CFG_BASELINE, 16'hFFFF);
        write_reg(lpwa_pkg::CFG_MAX_LOOP, 16'd0);
        send_sample($urandom, $urandom, 16'hFFFF);
        wait_idle();
    endtask

    // Counter deltas, taken against zero since no counter sample was latched yet.
    task automatic test_counter_mode();
        write_reg(lpwa_pkg::CFG_SOURCE_MODE, 16'(lpwa_pkg::MODE_TICKS));
        write_reg(lpwa_pkg::CFG_BASELINE, lpwa_pkg::BASELINE_RST);
        write_reg(lpwa_pkg::CFG_MAX_LOOP, lpwa_pkg::MAX_LOOP_RST);
        send_sample(32'd100, 32'd300, 16'($urandom));
        send_sample(32'd100, 32'd300, 16'($urandom));             // zero total
        send_sample(32'd200, 32'd300, 16'($urandom));             // all busy
        send_sample(32'd200, 32'd1300, 16'($urandom));            // all idle
        send_sample(32'hFFFF_FFF0, 32'hFFFF_FFF0, 16'($urandom));
        send_sample(32'h0000_0010, 32'h0000_0020, 16'($urandom)); // both wrap
        send_sample(32'h0000_000F, 32'h0000_001F, 16'($urandom)); // largest deltas
        send_sample(32'hFFFF_FFFF, 32'h0000_001F, 16'($urandom));
        send_sample(32'h0000_0000, 32'hFFFF_FFFF, 16'($urandom));
        act_cnt = 32'h0;
        idl_cnt = 32'hFFFF_FFFF;
        wait_idle();
    endtask

    // Random phases: fresh limits and mode per phase, mostly plausible samples.
    task automatic test_random_phases();
        int          r;
        int          lo;
        int          hi;
        int unsigned tot;
        logic [31:0] da;
        logic [31:0] di;
        logic [15:0] base;
        logic [15:0] maxv;
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            idle_on = (ph < RAND_PHASES - 2) && ($urandom_range(0, 3) != 0);
            r = $urandom_range(0, 5);
            base = (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF : 16'($urandom_range(0, 2000));
            r = $urandom_range(0, 5);
            if (r == 0)
                maxv = 16'd0;
            else if (r == 1)
                maxv = 16'hFFFF;
            else if (r == 2)
                maxv = base;
            else
                maxv = 16'((int'(base) + $urandom_range(1, 20000) > 65535) ? 65535 :
                           int'(base) + $urandom_range(1, 20000));
            write_reg(lpwa_pkg::CFG_MAX_LOOP, maxv);
            write_reg(lpwa_pkg::CFG_BASELINE, base);
            write_reg(lpwa_pkg::CFG_SOURCE_MODE,
                      16'(ph[0] ? lpwa_pkg::MODE_LOOP : lpwa_pkg::MODE_TICKS));
            lo = (base > 200) ? int'(base) - 200 : 0;
            hi = ((base > maxv) ? int'(base) : int'(maxv)) + 200;
            if (hi > 65535)
                hi = 65535;
            for (int i = 0; i < PHASE_SAMPLES; i++) begin
                if (cur_mode == lpwa_pkg::MODE_LOOP) begin
                    r = $urandom_range(0, 9);
                    send_sample($urandom, $urandom,
                                (r == 0) ? 16'($urandom) : (r == 1) ? 16'd0 :
                                (r == 2) ? 16'hFFFF : 16'($urandom_range(lo, hi)));
                end else begin
                    r = $urandom_range(0, 19);
                    case (r)
                        0: begin act_cnt = $urandom; idl_cnt = $urandom; end
                        1: ;                                      // zero total
                        2: act_cnt += $urandom_range(1, 5000);
                        3: idl_cnt += $urandom_range(1, 5000);
                        4: begin act_cnt += $urandom; idl_cnt += $urandom; end
                        default: begin
                            tot = $urandom_range(1, 100000);
                            da  = $urandom_range(0, tot);
                            di  = tot - da;
                            act_cnt += da;
                            idl_cnt += di;
                        end
                    endcase
                    send_sample(act_cnt, idl_cnt, 16'($urandom));
                end
            end
            wait_idle();
        end
    endtask

    // result receiver: random stall bursts while idling is on
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (idle_on && aresetn && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    // check each result against the oldest pending average
    always @(posedge aclk) begin
        lpwa_pkg::out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_avgs.size() == 0) begin
                errors++;
                $display("%0t: unexpected result short=%0d mid=%0d long=%0d", $time,
                         m_data.avg_short, m_data.avg_mid, m_data.avg_long);
            end else begin
                want = pending_avgs.pop_front();
                avgs_checked++;
                if (m_data !== want) begin
                    errors++;
                    $display("%0t: mismatch short/mid/long exp %0d/%0d/%0d got %0d/%0d/%0d",
                             $time, want.avg_short, want.avg_mid, want.avg_long,
                             m_data.avg_short, m_data.avg_mid, m_data.avg_long);
                end
            end
        end
    end

    // watchdog: too long without any handshake or register write
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we || !aresetn)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("load_percent_window_averager_unit_test failed");
            $finish;
        end
    end

    initial begin
        // mirror at reset
        cur_mode    = lpwa_pkg::MODE_TICKS;
        cur_base    = lpwa_pkg::BASELINE_RST;
        cur_max     = lpwa_pkg::MAX_LOOP_RST;
        primed      = 1'b0;
        last_active = '0;
        last_idle   = '0;
        win_depth[0] = lpwa_pkg::SHORT_DEPTH_DEF;
        win_depth[1] = lpwa_pkg::MID_DEPTH_DEF;
        win_depth[2] = lpwa_pkg::LONG_DEPTH_DEF;
        for (int w = 0; w < 3; w++) begin
            win_pos[w] = 0;
            win_sum[w] = 0;
            for (int k = 0; k < lpwa_pkg::LONG_DEPTH_DEF; k++)
                win_ring[w][k] = '0;
        end
        idle_on      = 1'b0;
        samples_sent = 0;
        reg_writes   = 0;
        act_cnt      = '0;
        idl_cnt      = '0;

        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_loop_time_mode();
        test_counter_mode();
        test_random_phases();
        wait_idle();

        $display("Sent %0d samples in both source modes over %0d register writes,",
                 samples_sent, reg_writes);
        $display("compared %0d window average results.", avgs_checked);
        if (errors == 0)
            $display("load_percent_window_averager_unit_test passed");
        else
            $display("load_percent_window_averager_unit_test failed");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/lpwa_pkg.sv
sv/lpwa_ram.sv
sv/lpwa_div.sv
sv/lpwa_window.sv
sv/load_percent_window_averager_unit.sv
tb/sv/load_percent_window_averager_unit_test.sv
